[rtl/slfpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfpr_pkg
// shared widths, register map and frame position codes of the sync/length
// framed packet receiver
// ----------------------------------------------------------------------------
package slfpr_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 9;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 5;
  localparam int REGIX_W = 3;

  // register indexes (byte address is 4 * index)
  localparam logic [REGIX_W-1:0] REG_SYNC_FIRST   = 3'd0;
  localparam logic [REGIX_W-1:0] REG_SYNC_SECOND  = 3'd1;
  localparam logic [REGIX_W-1:0] REG_ACCEPTED_ID  = 3'd2;
  localparam logic [REGIX_W-1:0] REG_MAX_PAYLOAD  = 3'd3;
  localparam logic [REGIX_W-1:0] REG_CHECK_ENABLE = 3'd4;

  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd45;

  // frame positions with a fixed meaning
  localparam logic [POS_W-1:0] POS_HUNT    = 9'd0;
  localparam logic [POS_W-1:0] POS_SYNC2   = 9'd1;
  localparam logic [POS_W-1:0] POS_ID      = 9'd2;
  localparam logic [POS_W-1:0] POS_COUNT   = 9'd3;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd4;

endpackage

[rtl/slfpr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfpr_if
// valid/ready channels: received bytes in, annotated bytes out
// ----------------------------------------------------------------------------
interface slfpr_in_if;
  logic                           valid;
  logic                           ready;
  logic [slfpr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfpr_out_if;
  logic                           valid;
  logic                           ready;
  logic [slfpr_pkg::BYTE_W-1:0]   data_byte;
  logic [slfpr_pkg::POS_W-1:0]    byte_index;
  logic                           in_frame;
  logic                           frame_end;
  logic                           frame_good;
  logic                           length_error;

  modport source (output valid, output data_byte, output byte_index, output in_frame,
                  output frame_end, output frame_good, output length_error,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_index, input in_frame,
                  input frame_end, input frame_good, input length_error,
                  output ready);
endinterface

[rtl/sync_length_framed_packet_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_framed_packet_receiver
// hunts two sync bytes and a message id, takes a count byte, collects the
// payload and two fletcher check bytes, and echoes every byte with its frame
// position and status flags
// ----------------------------------------------------------------------------
// an accepted byte's result item is in the output register in the next cycle
// throughput: one byte per cycle unless a full output register stalls; the frame
//   state update is one short pass from frame state registers to output register
// a full output register holds its item while the next byte is taken in the
//   same cycle it is read out
// reset (rst, synchronous, active high): hunting the first sync byte, sums and
//   count cleared, registers to defaults (max_payload 45, others 0), output empty
// ----------------------------------------------------------------------------
module sync_length_framed_packet_receiver (
  input  logic                             clk,
  input  logic                             rst,
  // apb-style configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slfpr_pkg::APB_AW-1:0]     paddr,
  input  logic [slfpr_pkg::APB_DW-1:0]     pwdata,
  output logic [slfpr_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  // byte channels
  slfpr_in_if.sink                         in_ch,
  slfpr_out_if.source                      out_ch
);

  localparam int BW = slfpr_pkg::BYTE_W;
  localparam int PW = slfpr_pkg::POS_W;

  // configuration registers
  logic [BW-1:0] sync_first;
  logic [BW-1:0] sync_second;
  logic [BW-1:0] accepted_id;
  logic [BW-1:0] max_payload;
  logic          check_enable;

  // frame state
  logic [PW-1:0] position;
  logic [BW-1:0] payload_count;
  logic [BW-1:0] sum_low;
  logic [BW-1:0] sum_high;
  logic [BW-1:0] received_check_low;

  logic [PW-1:0] position_next;
  logic [BW-1:0] payload_count_next;
  logic [BW-1:0] sum_low_next;
  logic [BW-1:0] sum_high_next;
  logic [BW-1:0] received_check_low_next;

  // output register
  logic          out_valid;
  logic [BW-1:0] out_data;
  logic [PW-1:0] out_index;
  logic          out_in_frame;
  logic          out_end;
  logic          out_good;
  logic          out_lerr;

  // per-byte result
  logic          accepted;
  logic          end_flag;
  logic          good_flag;
  logic          lerr_flag;

  logic                               wr_en;
  logic [slfpr_pkg::REGIX_W-1:0]      reg_ix;
  logic [BW-1:0]                      b;
  logic [PW-1:0]                      k;
  logic                               do_sum;
  logic                               restart_sum;
  logic [BW-1:0]                      sum_low_base;
  logic [BW-1:0]                      sum_high_base;
  logic                               take;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign reg_ix = paddr[slfpr_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first   <= '0;
      sync_second  <= '0;
      accepted_id  <= '0;
      max_payload  <= slfpr_pkg::MAX_PAYLOAD_RESET;
      check_enable <= 1'b0;
    end else if (wr_en) begin
      // addresses past the register list are dropped
      unique case (reg_ix)
        slfpr_pkg::REG_SYNC_FIRST:   sync_first   <= pwdata[BW-1:0];
        slfpr_pkg::REG_SYNC_SECOND:  sync_second  <= pwdata[BW-1:0];
        slfpr_pkg::REG_ACCEPTED_ID:  accepted_id  <= pwdata[BW-1:0];
        slfpr_pkg::REG_MAX_PAYLOAD:  max_payload  <= pwdata[BW-1:0];
        slfpr_pkg::REG_CHECK_ENABLE: check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_ix)
      slfpr_pkg::REG_SYNC_FIRST:   prdata[BW-1:0] = sync_first;
      slfpr_pkg::REG_SYNC_SECOND:  prdata[BW-1:0] = sync_second;
      slfpr_pkg::REG_ACCEPTED_ID:  prdata[BW-1:0] = accepted_id;
      slfpr_pkg::REG_MAX_PAYLOAD:  prdata[BW-1:0] = max_payload;
      slfpr_pkg::REG_CHECK_ENABLE: prdata[0]      = check_enable;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  // take a byte whenever the output register is empty or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------- frame logic
  assign b = in_ch.rx_byte;
  // payload offset, only meaningful once past the count byte
  assign k = position - slfpr_pkg::POS_PAYLOAD;

  always_comb begin
    accepted                = 1'b0;
    end_flag                = 1'b0;
    good_flag               = 1'b0;
    lerr_flag               = 1'b0;
    do_sum                  = 1'b0;
    restart_sum             = 1'b0;
    position_next           = position;
    payload_count_next      = payload_count;
    received_check_low_next = received_check_low;

    priority if (position == slfpr_pkg::POS_HUNT) begin
      if (b == sync_first) begin
        accepted      = 1'b1;
        position_next = slfpr_pkg::POS_SYNC2;
      end
    end else if (position == slfpr_pkg::POS_SYNC2) begin
      // a wrong second sync byte is not retried as a first sync byte
      if (b == sync_second) begin
        accepted      = 1'b1;
        position_next = slfpr_pkg::POS_ID;
      end else begin
        position_next = slfpr_pkg::POS_HUNT;
      end
    end else if (position == slfpr_pkg::POS_ID) begin
      if (b == accepted_id) begin
        accepted      = 1'b1;
        do_sum        = 1'b1;
        restart_sum   = 1'b1;
        position_next = slfpr_pkg::POS_COUNT;
      end else begin
        position_next = slfpr_pkg::POS_HUNT;
      end
    end else if (position == slfpr_pkg::POS_COUNT) begin
      if (b > max_payload) begin
        lerr_flag     = 1'b1;
        position_next = slfpr_pkg::POS_HUNT;
      end else begin
        accepted           = 1'b1;
        do_sum             = 1'b1;
        payload_count_next = b;
        position_next      = slfpr_pkg::POS_PAYLOAD;
      end
    end else begin
      accepted = 1'b1;
      priority if (k < {1'b0, payload_count}) begin
        // payload byte
        do_sum        = 1'b1;
        position_next = position + 1'b1;
      end else if (k == {1'b0, payload_count}) begin
        // first check byte, compared with sum_low at frame end
        received_check_low_next = b;
        position_next           = position + 1'b1;
      end else begin
        // second check byte closes the frame
        end_flag      = 1'b1;
        good_flag     = !check_enable ||
                        ((received_check_low == sum_low) && (b == sum_high));
        position_next = slfpr_pkg::POS_HUNT;
      end
    end
  end

  // fletcher-style update with 8-bit sums (modulo 256), restarted at the id byte
  assign sum_low_base  = restart_sum ? '0 : sum_low;
  assign sum_high_base = restart_sum ? '0 : sum_high;
  assign sum_low_next  = do_sum ? (sum_low_base + b) : sum_low;
  assign sum_high_next = do_sum ? (sum_high_base + sum_low_next) : sum_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= slfpr_pkg::POS_HUNT;
      payload_count      <= '0;
      sum_low            <= '0;
      sum_high           <= '0;
      received_check_low <= '0;
    end else if (take) begin
      position           <= position_next;
      payload_count      <= payload_count_next;
      sum_low            <= sum_low_next;
      sum_high           <= sum_high_next;
      received_check_low <= received_check_low_next;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset, loaded with each item
  always_ff @(posedge clk) begin
    if (take) begin
      out_data     <= b;
      out_index    <= position;
      out_in_frame <= accepted;
      out_end      <= end_flag;
      out_good     <= good_flag;
      out_lerr     <= lerr_flag;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.data_byte    = out_data;
  assign out_ch.byte_index   = out_index;
  assign out_ch.in_frame     = out_in_frame;
  assign out_ch.frame_end    = out_end;
  assign out_ch.frame_good   = out_good;
  assign out_ch.length_error = out_lerr;

endmodule
